### design/rht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rht_pkg;

  localparam int HANDLE_W    = 32;
  localparam int SIZE_W      = 34;
  localparam int FRAME_W     = 40;
  localparam int FLAGS_W     = 5;
  localparam int DIM_W       = 16;
  localparam int PID_W       = 32;
  localparam int REFS_W      = 16;
  localparam int RSIZE_W     = 35;
  localparam int RPAGES_W    = 23;
  localparam int LIVE_W      = 7;
  localparam int MAX_RESULTS = 64;
  localparam int REL_W       = 7;
  localparam int SCANOUT_BIT = 2;
  localparam logic [REFS_W-1:0] REF_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ACT_CREATE  = 3'd0,
    ACT_SURFACE = 3'd1,
    ACT_MAP     = 3'd2,
    ACT_UNMAP   = 3'd3,
    ACT_DESTROY = 3'd4,
    ACT_QUERY   = 3'd5,
    ACT_OWNER   = 3'd6,
    ACT_CLEANUP = 3'd7
  } act_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NOSLOT   = 3'd1,
    STS_ALLOC    = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_BADDIM   = 3'd4
  } sts_code_t;

  typedef struct packed {
    act_t                action;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size_bytes;
    logic [FLAGS_W-1:0]  region_flags;
    logic [FRAME_W-1:0]  page_frame;
    logic [DIM_W-1:0]    pix_width;
    logic [DIM_W-1:0]    pix_height;
    logic [PID_W-1:0]    process_id;
  } rht_req_t;

  typedef struct packed {
    sts_code_t           status;
    logic [HANDLE_W-1:0] result_handle;
    logic [FRAME_W-1:0]  base_frame;
    logic [RSIZE_W-1:0]  region_size;
    logic [FLAGS_W-1:0]  flags_out;
    logic                release_valid;
    logic [FRAME_W-1:0]  release_frame;
    logic [RPAGES_W-1:0] release_pages;
    logic [LIVE_W-1:0]   live_regions;
    logic                last;
  } rht_res_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic scan_run;
    logic apply;
    logic load_end;
    logic load_baddim;
    logic mark_last;
  } rht_cmd_t;

  typedef struct packed {
    logic bad_dims;
    logic hit;
    logic scan_end;
    logic cleanup;
    logic rel_next;
  } rht_sts_t;

endpackage
`default_nettype wire

### design/rht_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rht_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] handle;
  logic [33:0] size_bytes;
  logic [4:0]  region_flags;
  logic [39:0] page_frame;
  logic [15:0] pix_width;
  logic [15:0] pix_height;
  logic [31:0] process_id;

  modport source (output valid, action, handle, size_bytes, region_flags, page_frame,
                  pix_width, pix_height, process_id, input ready);
  modport sink (input valid, action, handle, size_bytes, region_flags, page_frame,
                pix_width, pix_height, process_id, output ready);
endinterface

interface rht_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] result_handle;
  logic [39:0] base_frame;
  logic [34:0] region_size;
  logic [4:0]  flags_out;
  logic        release_valid;
  logic [39:0] release_frame;
  logic [22:0] release_pages;
  logic [6:0]  live_regions;
  logic        last;

  modport source (output valid, status, result_handle, base_frame, region_size, flags_out,
                  release_valid, release_frame, release_pages, live_regions, last,
                  input ready);
  modport sink (input valid, status, result_handle, base_frame, region_size, flags_out,
                release_valid, release_frame, release_pages, live_regions, last,
                output ready);
endinterface
`default_nettype wire

### design/rht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rht_pkg::rht_cmd_t cmd,
  input  rht_pkg::rht_sts_t sts
);
  import rht_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_APPLY = 6'b001000,
    S_MID   = 6'b010000,
    S_LAST  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.bad_dims) begin
          cmd.load_baddim = 1'b1;
          state_nxt       = S_LAST;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          state_nxt = S_APPLY;
        end else if (sts.scan_end) begin
          if (sts.cleanup && pend_r) begin
            cmd.mark_last = 1'b1;
          end else begin
            cmd.load_end = 1'b1;
          end
          state_nxt = S_LAST;
        end
      end
      S_APPLY: begin
        if (sts.cleanup) begin
          if (sts.rel_next && pend_r) begin
            // flush the buffered release before loading the next one
            state_nxt = S_MID;
          end else begin
            cmd.apply = 1'b1;
            if (sts.rel_next) begin
              pend_nxt = 1'b1;
            end
            state_nxt = S_SCAN;
          end
        end else begin
          cmd.apply = 1'b1;
          state_nxt = S_LAST;
        end
      end
      S_MID: begin
        out_valid = 1'b1;
        if (out_ready) begin
          pend_nxt  = 1'b0;
          state_nxt = S_APPLY;
        end
      end
      S_LAST: begin
        out_valid = 1'b1;
        if (out_ready) begin
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

### design/rht_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module rht_dp #(
  parameter int SLOTS      = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rht_pkg::rht_cmd_t cmd,
  output rht_pkg::rht_sts_t sts,
  input  rht_pkg::rht_req_t in_req,
  output rht_pkg::rht_res_t res
);
  import rht_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int IW = $clog2(SLOTS + 1);
  localparam int SH = $clog2(PAGE_BYTES);
  localparam int PW = SIZE_W + 1 - SH;
  localparam logic [IW-1:0] SLOTS_I = IW'(SLOTS);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [FRAME_W-1:0]  frame;
    logic [PW-1:0]       pages;
    logic [FLAGS_W-1:0]  flags;
    logic [PID_W-1:0]    owner;
    logic [REFS_W-1:0]   refs;
  } rec_t;

  rec_t mem [SLOTS];
  rec_t rd_r, sel_rec_r, wr_rec;

  rht_req_t            req_r;
  rht_res_t            res_r, app_res, end_res, bad_res;
  logic [SIZE_W-1:0]   size_r;
  logic [AW-1:0]       pipe_idx_r, sel_idx_r;
  logic                pipe_vld_r, sel_pend_r;
  logic [IW-1:0]       scan_idx_r;
  logic [SLOTS-1:0]    active_r, pending_r;
  logic [HANDLE_W-1:0] nh_r, nh_nxt;
  logic [IW-1:0]       total_r, total_nxt;
  logic [REL_W-1:0]    nrel_r;

  logic                is_create, is_clean, limit, cur_act, cur_pend, match;
  logic [31:0]         area;
  logic [PW-1:0]       new_pages;
  logic [REFS_W-1:0]   ref_dec, ref_inc;
  logic [RSIZE_W-1:0]  pg_ext;
  logic                wr_en, set_act, set_pend, do_rel;

  assign is_create = (req_r.action == ACT_CREATE) || (req_r.action == ACT_SURFACE);
  assign is_clean  = (req_r.action == ACT_CLEANUP);
  assign limit     = is_clean && (nrel_r == REL_W'(MAX_RESULTS));
  assign cur_act   = active_r[pipe_idx_r];
  assign cur_pend  = pending_r[pipe_idx_r];

  always_comb begin
    priority if (is_create) begin
      match = !cur_act;
    end else if (is_clean) begin
      match = cur_act && !cur_pend && (rd_r.owner == req_r.process_id);
    end else begin
      match = cur_act && (rd_r.handle == req_r.handle);
    end
  end

  assign sts.hit      = pipe_vld_r && !limit && match;
  assign sts.scan_end = limit || (!pipe_vld_r && (scan_idx_r == SLOTS_I));
  assign sts.cleanup  = is_clean;
  assign sts.rel_next = (sel_rec_r.refs <= REFS_W'(1));
  assign sts.bad_dims = (req_r.action == ACT_SURFACE) &&
                        ((req_r.pix_width == '0) || (req_r.pix_height == '0));

  assign area      = 32'(req_r.pix_width) * 32'(req_r.pix_height);
  assign new_pages = PW'(size_r >> SH) + PW'(|size_r[SH-1:0]);
  assign ref_dec   = (sel_rec_r.refs == '0) ? sel_rec_r.refs : sel_rec_r.refs - 1'b1;
  assign ref_inc   = (sel_rec_r.refs == REF_MAX) ? sel_rec_r.refs : sel_rec_r.refs + 1'b1;
  assign pg_ext    = RSIZE_W'(sel_rec_r.pages);

  always_comb begin
    wr_en     = 1'b0;
    wr_rec    = sel_rec_r;
    set_act   = 1'b0;
    set_pend  = 1'b0;
    do_rel    = 1'b0;
    nh_nxt    = nh_r;
    total_nxt = total_r;
    app_res   = '0;
    app_res.status = STS_OK;
    unique case (req_r.action)
      ACT_CREATE, ACT_SURFACE: begin
        if (req_r.page_frame == '0) begin
          app_res.status = STS_ALLOC;
        end else begin
          wr_en        = 1'b1;
          set_act      = 1'b1;
          wr_rec.handle = nh_r;
          wr_rec.frame = req_r.page_frame;
          wr_rec.pages = new_pages;
          wr_rec.flags = req_r.region_flags;
          wr_rec.owner = ((req_r.action == ACT_SURFACE) && req_r.region_flags[SCANOUT_BIT])
                         ? req_r.process_id : '0;
          wr_rec.refs  = REFS_W'(1);
          nh_nxt       = (nh_r + 1'b1 == '0) ? HANDLE_W'(1) : nh_r + 1'b1;
          total_nxt    = total_r + 1'b1;
          app_res.result_handle = nh_r;
        end
      end
      ACT_MAP: begin
        wr_en       = 1'b1;
        wr_rec.refs = ref_inc;
        app_res.base_frame = sel_rec_r.frame;
      end
      ACT_UNMAP: begin
        wr_en       = 1'b1;
        wr_rec.refs = ref_dec;
        do_rel      = sel_pend_r && (ref_dec == '0);
      end
      ACT_DESTROY, ACT_CLEANUP: begin
        wr_en       = 1'b1;
        wr_rec.refs = ref_dec;
        if (ref_dec != '0) begin
          set_pend = 1'b1;
        end else begin
          do_rel = 1'b1;
        end
      end
      ACT_QUERY: begin
        app_res.base_frame  = sel_rec_r.frame;
        app_res.region_size = RSIZE_W'({sel_rec_r.pages, {SH{1'b0}}});
        app_res.flags_out   = sel_rec_r.flags;
      end
      ACT_OWNER: begin
        wr_en        = 1'b1;
        wr_rec.owner = req_r.process_id;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    if (do_rel) begin
      total_nxt = (total_r == '0) ? total_r : total_r - 1'b1;
      if (sel_rec_r.pages != '0) begin
        app_res.release_valid = 1'b1;
        app_res.release_frame = sel_rec_r.frame;
        app_res.release_pages = pg_ext[RPAGES_W-1:0];
      end
    end
    app_res.live_regions = LIVE_W'(total_nxt);
    app_res.last         = !is_clean;
  end

  always_comb begin
    end_res = '0;
    priority if (is_create) begin
      end_res.status = STS_NOSLOT;
    end else if (is_clean) begin
      end_res.status = STS_OK;
    end else begin
      end_res.status = STS_NOTFOUND;
    end
    end_res.live_regions = LIVE_W'(total_r);
    end_res.last         = 1'b1;
  end

  always_comb begin
    bad_res              = '0;
    bad_res.status       = STS_BADDIM;
    bad_res.live_regions = LIVE_W'(total_r);
    bad_res.last         = 1'b1;
  end

  // slot record store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.apply && wr_en) begin
      mem[sel_idx_r] <= wr_rec;
    end
    rd_r <= mem[scan_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= '0;
      pending_r  <= '0;
      nh_r       <= HANDLE_W'(1);
      total_r    <= '0;
      pipe_vld_r <= 1'b0;
      scan_idx_r <= '0;
      nrel_r     <= '0;
    end else begin
      if (cmd.load) begin
        scan_idx_r <= '0;
        pipe_vld_r <= 1'b0;
        nrel_r     <= '0;
      end
      if (cmd.scan_run) begin
        if (sts.hit) begin
          pipe_vld_r <= 1'b0;
          scan_idx_r <= IW'(pipe_idx_r) + IW'(1);
        end else begin
          pipe_vld_r <= (scan_idx_r != SLOTS_I);
          if (scan_idx_r != SLOTS_I) begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
        end
      end
      if (cmd.apply) begin
        nh_r    <= nh_nxt;
        total_r <= total_nxt;
        if (set_act) begin
          active_r[sel_idx_r]  <= 1'b1;
          pending_r[sel_idx_r] <= 1'b0;
        end
        if (set_pend) begin
          pending_r[sel_idx_r] <= 1'b1;
        end
        if (do_rel) begin
          active_r[sel_idx_r]  <= 1'b0;
          pending_r[sel_idx_r] <= 1'b0;
          if (is_clean) begin
            nrel_r <= nrel_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.prep) begin
      size_r <= (req_r.action == ACT_SURFACE) ? {area, 2'b00} : req_r.size_bytes;
    end
    if (cmd.scan_run) begin
      pipe_idx_r <= scan_idx_r[AW-1:0];
      if (sts.hit) begin
        sel_idx_r  <= pipe_idx_r;
        sel_rec_r  <= rd_r;
        sel_pend_r <= cur_pend;
      end
    end
    // a cleanup hit that only marks pending keeps the buffered word
    if (cmd.apply && (!is_clean || do_rel)) begin
      res_r <= app_res;
    end else if (cmd.load_end) begin
      res_r <= end_res;
    end else if (cmd.load_baddim) begin
      res_r <= bad_res;
    end else if (cmd.mark_last) begin
      res_r.last <= 1'b1;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

### design/refcounted_region_handle_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake          Word
// in_bus    in   valid/ready        request: action, handle, size, flags, frame, dims, pid
// out_bus   out  valid/ready        result: status, handle, frame, size, flags, release, last
//
// One request at a time. A request is loaded and its size prepared, then the slot table
// is scanned through its single read port, one slot a cycle, then a hit is applied and
// the result words are offered. A surface with a zero dimension skips the scan.
// Cleanup resumes its scan after each hit.
// Reset is synchronous; slot valid bits clear at once, no clearing pass.
// A stalled result holds in the output register; the next request waits for the last word.
module refcounted_region_handle_table #(
  parameter int SLOTS      = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  rht_in_if.sink    in_bus,
  rht_out_if.source out_bus
);
  import rht_pkg::*;

  rht_cmd_t cmd;
  rht_sts_t sts;
  rht_req_t req;
  rht_res_t res;

  assign req.action       = act_t'(in_bus.action);
  assign req.handle       = in_bus.handle;
  assign req.size_bytes   = in_bus.size_bytes;
  assign req.region_flags = in_bus.region_flags;
  assign req.page_frame   = in_bus.page_frame;
  assign req.pix_width    = in_bus.pix_width;
  assign req.pix_height   = in_bus.pix_height;
  assign req.process_id   = in_bus.process_id;

  rht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rht_dp #(
    .SLOTS      (SLOTS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_req (req),
    .res    (res)
  );

  assign out_bus.status        = res.status;
  assign out_bus.result_handle = res.result_handle;
  assign out_bus.base_frame    = res.base_frame;
  assign out_bus.region_size   = res.region_size;
  assign out_bus.flags_out     = res.flags_out;
  assign out_bus.release_valid = res.release_valid;
  assign out_bus.release_frame = res.release_frame;
  assign out_bus.release_pages = res.release_pages;
  assign out_bus.live_regions  = res.live_regions;
  assign out_bus.last          = res.last;

endmodule
`default_nettype wire

### design/rht_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module rht_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic        out_release_valid,
  input logic [39:0] out_release_frame,
  input logic [22:0] out_release_pages
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("request taken while busy or result too early");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("not idle after final word");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request accepted while a result is pending");

  a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_release_valid |-> out_release_frame == '0 && out_release_pages == '0)
    else $error("release fields set without release");

endmodule

bind refcounted_region_handle_table rht_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_bus.valid),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_last          (out_bus.last),
  .out_release_valid (out_bus.release_valid),
  .out_release_frame (out_bus.release_frame),
  .out_release_pages (out_bus.release_pages)
);
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rht_pkg::*;

  localparam int NSLOT = 64;
  localparam longint unsigned PAGE = 4096;
  localparam int LIMIT = 8000000;

  logic clk;
  logic rst_n;
  rht_in_if  in_bus();
  rht_out_if out_bus();

  refcounted_region_handle_table uut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus)
  );

  typedef struct {
    rht_req_t req;
    bit       typed;
    rht_res_t res;
  } row_t;

  // shadow of the slot table
  bit                  sl_act[NSLOT];
  bit                  sl_pend[NSLOT];
  logic [31:0]         sl_hdl[NSLOT];
  logic [39:0]         sl_frame[NSLOT];
  longint unsigned     sl_pages[NSLOT];
  logic [4:0]          sl_flags[NSLOT];
  logic [31:0]         sl_owner[NSLOT];
  int unsigned         sl_refs[NSLOT];
  logic [31:0]         nxt_hdl;
  int unsigned         live_cnt;

  rht_res_t expected_words[$];
  row_t     dir_rows[$];
  int       errors, shown, cycles;
  int       n_sent, n_words, n_release, n_noslot;
  bit       idle_on;
  int       stall_left;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(0, 2);
    if (p < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic rht_res_t word0(sts_code_t st, logic [31:0] h, logic last);
    rht_res_t w;
    w = '0;
    w.status = st;
    w.result_handle = h;
    w.live_regions = live_cnt[6:0];
    w.last = last;
    return w;
  endfunction

  function automatic rht_res_t free_slot(int i, logic last);
    rht_res_t w;
    bit rv;
    rv = sl_pages[i] > 0;
    w = '0;
    w.status = STS_OK;
    w.release_valid = rv;
    w.release_frame = rv ? sl_frame[i] : '0;
    w.release_pages = rv ? sl_pages[i][22:0] : '0;
    sl_act[i] = 0;
    sl_pend[i] = 0;
    sl_refs[i] = 0;
    sl_frame[i] = '0;
    sl_pages[i] = 0;
    if (live_cnt > 0) live_cnt--;
    w.live_regions = live_cnt[6:0];
    w.last = last;
    return w;
  endfunction

  function automatic rht_res_t make_region(longint unsigned sz, logic [4:0] fl,
                                           logic [39:0] fr, logic [31:0] own);
    int s;
    s = -1;
    for (int i = 0; i < NSLOT; i++)
      if (!sl_act[i] && s < 0) s = i;
    if (s < 0) return word0(STS_NOSLOT, '0, 1'b1);
    if (fr == 0) return word0(STS_ALLOC, '0, 1'b1);
    sl_act[s] = 1;
    sl_pend[s] = 0;
    sl_hdl[s] = nxt_hdl;
    sl_frame[s] = fr;
    sl_pages[s] = sz / PAGE + ((sz % PAGE) != 0);
    sl_flags[s] = fl;
    sl_owner[s] = own;
    sl_refs[s] = 1;
    nxt_hdl++;
    if (nxt_hdl == 0) nxt_hdl = 1;
    live_cnt++;
    return word0(STS_OK, sl_hdl[s], 1'b1);
  endfunction

  function automatic void table_step(rht_req_t r);
    int i, n;
    rht_res_t w;
    longint unsigned area;
    i = -1;
    n = 0;
    case (r.action)
      ACT_CREATE: begin
        expected_words.push_back(make_region(64'(r.size_bytes), r.region_flags,
                                             r.page_frame, '0));
        return;
      end
      ACT_SURFACE: begin
        if (r.pix_width == 0 || r.pix_height == 0) begin
          expected_words.push_back(word0(STS_BADDIM, '0, 1'b1));
          return;
        end
        area = 64'(r.pix_width) * 64'(r.pix_height) * 64'd4;
        expected_words.push_back(make_region(area, r.region_flags, r.page_frame,
          r.region_flags[SCANOUT_BIT] ? r.process_id : '0));
        return;
      end
      ACT_CLEANUP: begin
        for (int k = 0; k < NSLOT && n < MAX_RESULTS; k++) begin
          if (!sl_act[k] || sl_pend[k] || sl_owner[k] != r.process_id) continue;
          if (sl_refs[k] > 0) sl_refs[k]--;
          if (sl_refs[k] > 0) sl_pend[k] = 1;
          else begin
            expected_words.push_back(free_slot(k, 1'b0));
            n++;
          end
        end
        if (n == 0) expected_words.push_back(word0(STS_OK, '0, 1'b1));
        else expected_words[expected_words.size()-1].last = 1'b1;
        return;
      end
      default: ;
    endcase
    for (int k = NSLOT - 1; k >= 0; k--)
      if (sl_act[k] && sl_hdl[k] == r.handle) i = k;
    if (i < 0) begin
      expected_words.push_back(word0(STS_NOTFOUND, '0, 1'b1));
      return;
    end
    w = word0(STS_OK, '0, 1'b1);
    case (r.action)
      ACT_MAP: begin
        if (sl_refs[i] < 65535) sl_refs[i]++;
        w.base_frame = sl_frame[i];
      end
      ACT_UNMAP: begin
        if (sl_refs[i] > 0) sl_refs[i]--;
        if (sl_pend[i] && sl_refs[i] == 0) w = free_slot(i, 1'b1);
      end
      ACT_DESTROY: begin
        if (sl_refs[i] > 0) sl_refs[i]--;
        if (sl_refs[i] > 0) sl_pend[i] = 1;
        else w = free_slot(i, 1'b1);
      end
      ACT_QUERY: begin
        w.base_frame = sl_frame[i];
        w.region_size = 35'((sl_pages[i] * PAGE) & 64'h7_FFFF_FFFF);
        w.flags_out = sl_flags[i];
      end
      default: sl_owner[i] = r.process_id;
    endcase
    expected_words.push_back(w);
  endfunction

  task automatic send(rht_req_t r);
    int g;
    g = idle_on ? gap_len() : 0;
    @(negedge clk);
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.action       <= r.action;
    in_bus.handle       <= r.handle;
    in_bus.size_bytes   <= r.size_bytes;
    in_bus.region_flags <= r.region_flags;
    in_bus.page_frame   <= r.page_frame;
    in_bus.pix_width    <= r.pix_width;
    in_bus.pix_height   <= r.pix_height;
    in_bus.process_id   <= r.process_id;
    do @(posedge clk); while (!in_bus.ready);
    table_step(r);
    n_sent++;
  endtask

  function automatic rht_req_t mk(act_t a, logic [31:0] h, logic [33:0] sz, logic [4:0] fl,
                                  logic [39:0] fr, logic [15:0] w, logic [15:0] ht,
                                  logic [31:0] pid);
    rht_req_t r;
    r.action = a;
    r.handle = h;
    r.size_bytes = sz;
    r.region_flags = fl;
    r.page_frame = fr;
    r.pix_width = w;
    r.pix_height = ht;
    r.process_id = pid;
    return r;
  endfunction

  function automatic void add_row(rht_req_t r, bit typed = 0, sts_code_t st = STS_OK,
                                  logic [31:0] h = '0, int live = 0);
    row_t row;
    row.req = r;
    row.typed = typed;
    row.res = '0;
    row.res.status = st;
    row.res.result_handle = h;
    row.res.live_regions = live[6:0];
    row.res.last = 1'b1;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [31:0] pick_handle();
    int live[$];
    for (int k = 0; k < NSLOT; k++) if (sl_act[k]) live.push_back(k);
    if (live.size() == 0 || $urandom_range(0, 99) < 15)
      return ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
    return sl_hdl[live[$urandom_range(0, live.size() - 1)]];
  endfunction

  function automatic logic [31:0] pick_pid();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd7;
      2: return 32'hFFFF_FFFF;
      3: return 32'd42;
      default: return $urandom;
    endcase
  endfunction

  function automatic rht_req_t rand_req();
    rht_req_t r;
    int p;
    p = $urandom_range(0, 99);
    r.action = p < 20 ? ACT_CREATE : p < 30 ? ACT_SURFACE : p < 45 ? ACT_MAP :
               p < 57 ? ACT_UNMAP : p < 72 ? ACT_DESTROY : p < 82 ? ACT_QUERY :
               p < 90 ? ACT_OWNER : ACT_CLEANUP;
    r.handle = pick_handle();
    p = $urandom_range(0, 9);
    r.size_bytes = p < 6 ? 34'($urandom_range(0, 20000)) :
                   p < 9 ? 34'({$urandom, $urandom}) : 34'($urandom_range(0, 64)) * 4096;
    r.region_flags = 5'($urandom);
    r.page_frame = $urandom_range(0, 19) == 0 ? 40'd0 : 40'({$urandom, $urandom});
    r.pix_width = $urandom_range(0, 19) == 0 ? 16'd0 :
                  $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(1, 256));
    r.pix_height = $urandom_range(0, 19) == 0 ? 16'd0 :
                   $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(1, 256));
    r.process_id = pick_pid();
    return r;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= gap_len();
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rht_res_t got, want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.status = sts_code_t'(out_bus.status);
      got.result_handle = out_bus.result_handle;
      got.base_frame = out_bus.base_frame;
      got.region_size = out_bus.region_size;
      got.flags_out = out_bus.flags_out;
      got.release_valid = out_bus.release_valid;
      got.release_frame = out_bus.release_frame;
      got.release_pages = out_bus.release_pages;
      got.live_regions = out_bus.live_regions;
      got.last = out_bus.last;
      n_words++;
      if (got.release_valid) n_release++;
      if (got.status == STS_NOSLOT) n_noslot++;
      if (expected_words.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("Unexpected word at cycle %0d: %p", cycles, got);
        end
      end else begin
        want = expected_words.pop_front();
        if (got.status !== want.status || got.result_handle !== want.result_handle ||
            got.base_frame !== want.base_frame || got.region_size !== want.region_size ||
            got.flags_out !== want.flags_out || got.release_valid !== want.release_valid ||
            got.release_frame !== want.release_frame ||
            got.release_pages !== want.release_pages ||
            got.live_regions !== want.live_regions || got.last !== want.last) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("Mismatch at cycle %0d", cycles);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  initial begin
    rht_req_t r;
    errors = 0; shown = 0; cycles = 0;
    n_sent = 0; n_words = 0; n_release = 0; n_noslot = 0;
    idle_on = 0;
    for (int k = 0; k < NSLOT; k++) begin
      sl_act[k] = 0; sl_pend[k] = 0; sl_hdl[k] = '0; sl_frame[k] = '0;
      sl_pages[k] = 0; sl_flags[k] = '0; sl_owner[k] = '0; sl_refs[k] = 0;
    end
    nxt_hdl = 32'd1;
    live_cnt = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.action = '0;
    in_bus.handle = '0;
    in_bus.size_bytes = '0;
    in_bus.region_flags = '0;
    in_bus.page_frame = '0;
    in_bus.pix_width = '0;
    in_bus.pix_height = '0;
    in_bus.process_id = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_row(mk(ACT_QUERY, 32'd1, 0, 0, 0, 0, 0, 0), 1, STS_NOTFOUND, 0, 0);
    add_row(mk(ACT_CREATE, 0, 34'd0, 5'd1, 40'd1, 0, 0, 0), 1, STS_OK, 1, 1);
    add_row(mk(ACT_CREATE, 0, 34'h3_FFFF_FFFF, 5'h1F, 40'hFF_FFFF_FFFF, 0, 0, 0),
            1, STS_OK, 2, 2);
    add_row(mk(ACT_CREATE, 0, 34'd4096, 0, 40'd0, 0, 0, 0), 1, STS_ALLOC, 0, 2);
    add_row(mk(ACT_SURFACE, 0, 0, 5'd4, 40'd9, 16'd0, 16'd10, 32'd77), 1, STS_BADDIM, 0, 2);
    add_row(mk(ACT_SURFACE, 0, 0, 5'd4, 40'd9, 16'd10, 16'd0, 32'd77), 1, STS_BADDIM, 0, 2);
    add_row(mk(ACT_SURFACE, 0, 0, 5'd4, 40'h123, 16'hFFFF, 16'hFFFF, 32'd77));
    add_row(mk(ACT_QUERY, 32'd2, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_QUERY, 32'd3, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_MAP, 32'd1, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_MAP, 32'd1, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_DESTROY, 32'd1, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_QUERY, 32'd1, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_OWNER, 32'd1, 0, 0, 0, 0, 0, 32'd9));
    add_row(mk(ACT_CLEANUP, 0, 0, 0, 0, 0, 0, 32'd9));
    add_row(mk(ACT_UNMAP, 32'd1, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_UNMAP, 32'd1, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_MAP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_CLEANUP, 0, 0, 0, 0, 0, 0, 32'd77));
    add_row(mk(ACT_CLEANUP, 0, 0, 0, 0, 0, 0, 32'd1234));
    add_row(mk(ACT_DESTROY, 32'd2, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_UNMAP, 32'd99, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_CREATE, 0, 34'd1, 5'd4, 40'd5, 0, 0, 32'd3));
    add_row(mk(ACT_CLEANUP, 0, 0, 0, 0, 0, 0, 32'd0));

    foreach (dir_rows[k]) begin
      send(dir_rows[k].req);
      if (dir_rows[k].typed) begin
        void'(expected_words.pop_back());
        expected_words.push_back(dir_rows[k].res);
      end
    end

    idle_on = 1;
    repeat (120) send(rand_req());

    // fill the table, overflow it, then sweep owner 0 with two cleanups
    idle_on = 0;
    while (live_cnt < NSLOT)
      send(mk(ACT_CREATE, 0, 34'($urandom_range(0, 9000)), 5'($urandom),
              {$urandom, 8'h1}, 0, 0, 0));
    idle_on = 1;
    send(mk(ACT_CREATE, 0, 34'd100, 0, 40'd0, 0, 0, 0));
    send(mk(ACT_SURFACE, 0, 0, 5'd4, 40'd7, 16'd2, 16'd2, 32'd5));
    send(mk(ACT_CLEANUP, 0, 0, 0, 0, 0, 0, 32'd0));
    send(mk(ACT_CLEANUP, 0, 0, 0, 0, 0, 0, 32'd0));

    repeat (120) send(rand_req());

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d requests, checked %0d result words (%0d page releases, %0d full-table",
             n_sent, n_words, n_release, n_noslot);
    $display("rejections) with random gaps and output stalls; %0d mismatches", errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
design/rht_pkg.sv
design/rht_if.sv
design/rht_ctrl.sv
design/rht_dp.sv
design/refcounted_region_handle_table.sv
design/rht_chk.sv
dv/testbench.sv
